/* design/vgds_pkg.sv */
// shared constants, types and helper functions of the visibility grid disc stamper
package vgds_pkg;

   // grid geometry
   localparam int GRID_SIDE      = 256;
   localparam int MAX_RADIUS     = 31;
   localparam int CELL_W         = 2;
   localparam int CELLS_PER_WORD = 8;
   localparam int WORD_W         = CELL_W * CELLS_PER_WORD;
   localparam int WORDS_PER_ROW  = (GRID_SIDE + CELLS_PER_WORD - 1) / CELLS_PER_WORD;
   localparam int WORD_COUNT     = GRID_SIDE * WORDS_PER_ROW;
   localparam int ADDR_W         = $clog2(WORD_COUNT);
   localparam int POS_W          = $clog2(GRID_SIDE);
   localparam int WCOL_W         = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
   localparam int SUB_W          = $clog2(CELLS_PER_WORD);
   localparam int RAD_W          = $clog2(MAX_RADIUS + 1);
   localparam int SQ_W           = 2 * RAD_W;
   localparam int DIST_W         = SQ_W + 1;
   localparam int COORD_W        = 12;
   localparam int NEW_W          = $clog2(CELLS_PER_WORD + 1);

   // item fields
   localparam int OP_W       = 2;
   localparam int TILE_W     = 10;
   localparam int RADIUS_W   = 5;
   localparam int COUNT_W    = 17;
   localparam int REQ_DATA_W = ((OP_W + 2 * TILE_W + RADIUS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CELL_W + COUNT_W + 7) / 8) * 8;

   localparam logic signed [COORD_W-1:0] GRID_MAX = COORD_W'(GRID_SIDE - 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_DECAY = 2'd0;
   localparam logic [OP_W-1:0] OP_STAMP = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // cell codes
   localparam logic [CELL_W-1:0] CELL_UNEXPLORED = 2'd0;
   localparam logic [CELL_W-1:0] CELL_EXPLORED   = 2'd1;
   localparam logic [CELL_W-1:0] CELL_VISIBLE    = 2'd2;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_DECAY,
      KIND_STAMP,
      KIND_QUERY
   } kind_type;

   // one word access handed from the sequencer to the read-modify-write stage
   typedef struct packed {
      logic                      en;
      kind_type                  kind;
      logic [ADDR_W-1:0]         addr;
      logic [CELLS_PER_WORD-1:0] mask;
      logic [SUB_W-1:0]          sel;
   } issue_type;

   typedef struct packed {
      logic ready;
      logic done;
   } seq_status_type;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [POS_W-1:0] row,
                                                   input logic [WCOL_W-1:0] wcol);
      return ADDR_W'(row) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(wcol);
   endfunction

   function automatic logic [SQ_W-1:0] square(input logic [RAD_W-1:0] v);
      return SQ_W'(v) * SQ_W'(v);
   endfunction

endpackage

/* design/visibility_grid_disc_stamper.sv */
// top level of the visibility grid disc stamper: stream ports, word pipeline, count, result register
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------------
//  req     | in  | req_tvalid/req_tready| operation, tile_x, tile_y, radius in req_tdata
//  rsp     | out | rsp_tvalid/rsp_tready| cell_state, explored_count in rsp_tdata
//
//  the grid is kept as words of 8 cells (2 bits each) in one ram, one word read per cycle,
//  modified and written back the next cycle; accesses inside one item never hit the same word
//  words: decay walks all WORD_COUNT words (8192 at a 256 grid), stamp rows * words per row of
//  the clipped disc (at most 63 * 9, none for a disc wholly off the grid), query at most one,
//  unused code none; the single ram read port paces these word walks
//  reset: a clearing pass writes every word (WORD_COUNT, 8192) to zero, req_tready low
//  the next item is taken while a result waits in rsp; a stalled rsp holds the block in its
//  last step until the result register frees
module visibility_grid_disc_stamper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // operation[1:0], tile_x[11:2], tile_y[21:12], radius[26:22], zero pad
   input  logic [vgds_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_state[1:0], explored_count[18:2], zero pad
   output logic [vgds_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int TW = vgds_pkg::TILE_W;
   localparam int OW = vgds_pkg::OP_W;

   // unpacked request fields
   logic [OW-1:0]                 operation;
   logic [TW-1:0]                 tile_x;
   logic [TW-1:0]                 tile_y;
   logic [vgds_pkg::RADIUS_W-1:0] radius;

   logic                          take;
   logic                          out_free;
   vgds_pkg::issue_type           issue;
   vgds_pkg::seq_status_type      status;

   // read-modify-write stage
   vgds_pkg::issue_type           pend_ff, pend_in;
   logic [vgds_pkg::WORD_W-1:0]   rd_data;
   logic                          wr_en;
   logic [vgds_pkg::WORD_W-1:0]   wr_data;
   logic [vgds_pkg::NEW_W-1:0]    new_cnt;
   logic [vgds_pkg::CELL_W-1:0]   cell_rd;

   logic [vgds_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [vgds_pkg::CELL_W-1:0]   cell_ff, cell_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vgds_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign operation = req_tdata[OW-1:0];
   assign tile_x    = req_tdata[OW +: TW];
   assign tile_y    = req_tdata[OW + TW +: TW];
   assign radius    = req_tdata[OW + 2*TW +: vgds_pkg::RADIUS_W];

   assign req_tready = status.ready;
   assign take       = req_tvalid && status.ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   vgds_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .operation (operation),
      .tile_x    (tile_x),
      .tile_y    (tile_y),
      .radius    (radius),
      .out_free  (out_free),
      .issue     (issue),
      .status    (status)
   );

   vgds_cell_ram #(
      .DEPTH (vgds_pkg::WORD_COUNT),
      .WIDTH (vgds_pkg::WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pend_ff.addr),
      .wr_data (wr_data),
      .rd_en   (issue.en),
      .rd_addr (issue.addr),
      .rd_data (rd_data)
   );

   vgds_word_modify u_modify (
      .pend    (pend_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .new_cnt (new_cnt),
      .cell_rd (cell_rd)
   );

   always_comb begin
      pend_in  = issue;
      count_in = count_ff;
      cell_in  = cell_ff;
      if (pend_ff.en) begin
         count_in = count_ff + vgds_pkg::COUNT_W'(new_cnt);
      end
      // non-query items report cell state zero
      if (take) begin
         cell_in = vgds_pkg::CELL_UNEXPLORED;
      end else if (pend_ff.en && (pend_ff.kind == vgds_pkg::KIND_QUERY)) begin
         cell_in = cell_rd;
      end
   end

   // result register, loaded once the last write-back has reached the count
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = vgds_pkg::RSP_DATA_W'({count_ff, cell_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff      <= cell_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/vgds_cell_ram.sv */
// single-port-write, single-port-read synchronous ram with registered read data
module vgds_cell_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/vgds_word_modify.sv */
// modify stage: turns a read word into its write-back value and counts new explored cells
module vgds_word_modify (
   input  vgds_pkg::issue_type                pend,
   input  logic [vgds_pkg::WORD_W-1:0]        rd_data,
   output logic                               wr_en,
   output logic [vgds_pkg::WORD_W-1:0]        wr_data,
   output logic [vgds_pkg::NEW_W-1:0]         new_cnt,
   output logic [vgds_pkg::CELL_W-1:0]        cell_rd
);

   always_comb begin
      logic [vgds_pkg::CELL_W-1:0] old;
      logic [vgds_pkg::CELL_W-1:0] nxt;
      wr_data = '0;
      new_cnt = '0;
      for (int k = 0; k < vgds_pkg::CELLS_PER_WORD; k++) begin
         old = rd_data[k*vgds_pkg::CELL_W +: vgds_pkg::CELL_W];
         nxt = old;
         case (pend.kind)
            vgds_pkg::KIND_CLEAR: begin
               nxt = vgds_pkg::CELL_UNEXPLORED;
            end
            vgds_pkg::KIND_DECAY: begin
               if (old == vgds_pkg::CELL_VISIBLE) begin
                  nxt = vgds_pkg::CELL_EXPLORED;
               end
            end
            vgds_pkg::KIND_STAMP: begin
               if (pend.mask[k]) begin
                  nxt = vgds_pkg::CELL_VISIBLE;
                  if (old == vgds_pkg::CELL_UNEXPLORED) begin
                     new_cnt = new_cnt + vgds_pkg::NEW_W'(1);
                  end
               end
            end
            default: begin
               nxt = old;
            end
         endcase
         wr_data[k*vgds_pkg::CELL_W +: vgds_pkg::CELL_W] = nxt;
      end
   end

   // queries only read
   assign wr_en   = pend.en && (pend.kind != vgds_pkg::KIND_QUERY);
   assign cell_rd = rd_data[pend.sel*vgds_pkg::CELL_W +: vgds_pkg::CELL_W];

endmodule

/* design/vgds_seq.sv */
// sequencer: walks the word addresses of the clearing pass, decay, stamp and query
module vgds_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [vgds_pkg::OP_W-1:0]        operation,
   input  logic [vgds_pkg::TILE_W-1:0]      tile_x,
   input  logic [vgds_pkg::TILE_W-1:0]      tile_y,
   input  logic [vgds_pkg::RADIUS_W-1:0]    radius,
   input  logic                             out_free,
   output vgds_pkg::issue_type              issue,
   output vgds_pkg::seq_status_type         status
);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_SETUP = 8'b00000100,
      ST_STAMP = 8'b00001000,
      ST_DECAY = 8'b00010000,
      ST_QUERY = 8'b00100000,
      ST_DRAIN = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   localparam int CW = vgds_pkg::COORD_W;
   localparam int PW = vgds_pkg::POS_W;
   localparam int RW = vgds_pkg::RAD_W;

   state_type state_ff, state_in;
   logic [vgds_pkg::ADDR_W-1:0]    ctr_ff, ctr_in;
   logic signed [CW-1:0]           cx_ff, cx_in, cy_ff, cy_in;
   logic [vgds_pkg::RADIUS_W-1:0]  radius_ff, radius_in;
   logic [vgds_pkg::DIST_W-1:0]    limit_ff, limit_in;
   logic [PW-1:0]                  xlo_ff, xlo_in, xhi_ff, xhi_in, yhi_ff, yhi_in;
   logic [PW-1:0]                  row_ff, row_in;
   logic [vgds_pkg::WCOL_W-1:0]    wlo_ff, wlo_in, whi_ff, whi_in, wcol_ff, wcol_in;

   // setup terms
   logic [RW-1:0]        r_clamp;
   logic signed [CW-1:0] r_s, xlo_s, xhi_s, ylo_s, yhi_s;
   logic                 empty;
   logic [PW-1:0]        xlo_p, xhi_p, ylo_p, yhi_p;

   // stamp row terms
   logic signed [CW-1:0]             dy_s;
   logic [RW-1:0]                    ady;
   logic [vgds_pkg::SQ_W-1:0]        dysq;
   logic [vgds_pkg::CELLS_PER_WORD-1:0] mask;
   logic                             on_grid;

   function automatic logic [RW-1:0] abs_rad(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] a;
      a = v[CW-1] ? -v : v;
      return RW'(a);
   endfunction

   always_comb begin
      if (radius_ff == '0) begin
         r_clamp = RW'(1);
      end else if (int'(radius_ff) > vgds_pkg::MAX_RADIUS) begin
         r_clamp = RW'(vgds_pkg::MAX_RADIUS);
      end else begin
         r_clamp = RW'(radius_ff);
      end
      r_s   = $signed({{(CW-RW){1'b0}}, r_clamp});
      xlo_s = cx_ff - r_s;
      xhi_s = cx_ff + r_s;
      ylo_s = cy_ff - r_s;
      yhi_s = cy_ff + r_s;
      empty = xhi_s[CW-1] || yhi_s[CW-1] ||
              (xlo_s > vgds_pkg::GRID_MAX) || (ylo_s > vgds_pkg::GRID_MAX);
      xlo_p = xlo_s[CW-1] ? '0 : PW'(xlo_s);
      ylo_p = ylo_s[CW-1] ? '0 : PW'(ylo_s);
      xhi_p = (xhi_s > vgds_pkg::GRID_MAX) ? PW'(vgds_pkg::GRID_SIDE - 1) : PW'(xhi_s);
      yhi_p = (yhi_s > vgds_pkg::GRID_MAX) ? PW'(vgds_pkg::GRID_SIDE - 1) : PW'(yhi_s);
   end

   // disc mask of the current word: in column range and inside r*r + r
   always_comb begin
      logic [CW-1:0]        xk;
      logic signed [CW-1:0] dx;
      logic [RW-1:0]        adx;
      logic [vgds_pkg::DIST_W-1:0] dist_sq;
      dy_s = $signed(CW'(row_ff)) - cy_ff;
      ady  = abs_rad(dy_s);
      dysq = vgds_pkg::square(ady);
      for (int k = 0; k < vgds_pkg::CELLS_PER_WORD; k++) begin
         xk      = CW'({wcol_ff, vgds_pkg::SUB_W'(k)});
         dx      = $signed(xk) - cx_ff;
         adx     = abs_rad(dx);
         dist_sq = vgds_pkg::DIST_W'(vgds_pkg::square(adx)) + vgds_pkg::DIST_W'(dysq);
         mask[k] = (xk >= CW'(xlo_ff)) && (xk <= CW'(xhi_ff)) && (dist_sq <= limit_ff);
      end
   end

   assign on_grid = !cx_ff[CW-1] && !cy_ff[CW-1] &&
                    (cx_ff <= vgds_pkg::GRID_MAX) && (cy_ff <= vgds_pkg::GRID_MAX);

   always_comb begin
      state_in  = state_ff;
      ctr_in    = ctr_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      radius_in = radius_ff;
      limit_in  = limit_ff;
      xlo_in    = xlo_ff;
      xhi_in    = xhi_ff;
      yhi_in    = yhi_ff;
      row_in    = row_ff;
      wlo_in    = wlo_ff;
      whi_in    = whi_ff;
      wcol_in   = wcol_ff;
      issue     = '0;
      issue.kind = vgds_pkg::KIND_CLEAR;
      status    = '0;
      case (state_ff)
         ST_CLEAR: begin
            issue.en   = 1'b1;
            issue.kind = vgds_pkg::KIND_CLEAR;
            issue.addr = ctr_ff;
            ctr_in     = ctr_ff + vgds_pkg::ADDR_W'(1);
            if (ctr_ff == vgds_pkg::ADDR_W'(vgds_pkg::WORD_COUNT - 1)) begin
               ctr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            status.ready = 1'b1;
            if (take) begin
               cx_in     = $signed({{(CW-vgds_pkg::TILE_W){tile_x[vgds_pkg::TILE_W-1]}}, tile_x});
               cy_in     = $signed({{(CW-vgds_pkg::TILE_W){tile_y[vgds_pkg::TILE_W-1]}}, tile_y});
               radius_in = radius;
               ctr_in    = '0;
               case (operation)
                  vgds_pkg::OP_DECAY: state_in = ST_DECAY;
                  vgds_pkg::OP_STAMP: state_in = ST_SETUP;
                  vgds_pkg::OP_QUERY: state_in = ST_QUERY;
                  default:            state_in = ST_DRAIN;
               endcase
            end
         end
         ST_SETUP: begin
            limit_in = vgds_pkg::DIST_W'(vgds_pkg::square(r_clamp)) + vgds_pkg::DIST_W'(r_clamp);
            xlo_in   = xlo_p;
            xhi_in   = xhi_p;
            yhi_in   = yhi_p;
            row_in   = ylo_p;
            wlo_in   = vgds_pkg::WCOL_W'(xlo_p >> vgds_pkg::SUB_W);
            wcol_in  = vgds_pkg::WCOL_W'(xlo_p >> vgds_pkg::SUB_W);
            whi_in   = vgds_pkg::WCOL_W'(xhi_p >> vgds_pkg::SUB_W);
            state_in = empty ? ST_DRAIN : ST_STAMP;
         end
         ST_STAMP: begin
            issue.en   = 1'b1;
            issue.kind = vgds_pkg::KIND_STAMP;
            issue.addr = vgds_pkg::word_addr(row_ff, wcol_ff);
            issue.mask = mask;
            if (wcol_ff == whi_ff) begin
               wcol_in = wlo_ff;
               row_in  = row_ff + PW'(1);
               if (row_ff == yhi_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               wcol_in = wcol_ff + vgds_pkg::WCOL_W'(1);
            end
         end
         ST_DECAY: begin
            issue.en   = 1'b1;
            issue.kind = vgds_pkg::KIND_DECAY;
            issue.addr = ctr_ff;
            ctr_in     = ctr_ff + vgds_pkg::ADDR_W'(1);
            if (ctr_ff == vgds_pkg::ADDR_W'(vgds_pkg::WORD_COUNT - 1)) begin
               ctr_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_QUERY: begin
            issue.en   = on_grid;
            issue.kind = vgds_pkg::KIND_QUERY;
            issue.addr = vgds_pkg::word_addr(PW'(cy_ff),
                                             vgds_pkg::WCOL_W'(PW'(cx_ff) >> vgds_pkg::SUB_W));
            issue.sel  = vgds_pkg::SUB_W'(cx_ff);
            state_in   = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               status.done = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ctr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      radius_ff <= radius_in;
      limit_ff  <= limit_in;
      xlo_ff    <= xlo_in;
      xhi_ff    <= xhi_in;
      yhi_ff    <= yhi_in;
      row_ff    <= row_in;
      wlo_ff    <= wlo_in;
      whi_ff    <= whi_in;
      wcol_ff   <= wcol_in;
   end

endmodule

/* design/vgds_checker.sv */
// port-level checks of the visibility grid disc stamper and their bind
module vgds_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [vgds_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vgds_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CW  = vgds_pkg::CELL_W;
   localparam int NW  = vgds_pkg::COUNT_W;
   localparam int PAD = vgds_pkg::RSP_DATA_W - CW - NW;

   logic [NW-1:0] last_cnt_ff, last_cnt_in;

   assign last_cnt_in = (rsp_tvalid && rsp_tready) ? rsp_tdata[CW +: NW] : last_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cnt_ff <= '0;
      end else begin
         last_cnt_ff <= last_cnt_in;
      end
   end

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while another is in work");

   // the reported explored count never goes down
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> rsp_tdata[CW +: NW] >= last_cnt_ff)
      else $error("explored count went down");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CW-1:0] <= vgds_pkg::CELL_VISIBLE) &&
                     (rsp_tdata[vgds_pkg::RSP_DATA_W-1 -: PAD] == '0))
      else $error("bad cell code or nonzero pad in result");

endmodule

bind visibility_grid_disc_stamper vgds_checker u_vgds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* bench/tb_visibility_grid_disc_stamper.sv */
// self-checking bench for the visibility grid disc stamper: directed edge cases, then random mixes
module tb_visibility_grid_disc_stamper;
   import vgds_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 20;
   localparam int CELL_TOTAL   = GRID_SIDE * GRID_SIDE;
   // the one operation code the block leaves unused
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // what one result transfer should carry
   typedef struct {
      logic [CELL_W-1:0]  cell_state;
      logic [COUNT_W-1:0] explored_count;
   } cell_report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // operation, tile_x, tile_y, radius, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // cell_state, explored_count, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   visibility_grid_disc_stamper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // bench copy of the grid and of the running explored count
   logic [CELL_W-1:0] grid_mirror [0:CELL_TOTAL-1];
   int unsigned       explored_mirror;

   // reports still owed by the block, oldest first
   cell_report_type pending_reports [$];
   cell_report_type oldest_report;

   int error_count;
   int reports_checked;
   int op_seen [4];
   // idle percentages of the sending and receiving side
   int sender_idle_pct;
   int receiver_idle_pct;
   // centre of the latest stamp, so queries can probe around it
   int last_cx;
   int last_cy;

   always #HALF_PERIOD clock = ~clock;

   function automatic bit grid_has(input int x, input int y);
      return x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE;
   endfunction

   // advance the mirror by one item and return the report it must produce
   function automatic cell_report_type apply_to_mirror(input logic [OP_W-1:0] op,
                                                       input logic signed [TILE_W-1:0] x,
                                                       input logic signed [TILE_W-1:0] y,
                                                       input logic [RADIUS_W-1:0] r);
      cell_report_type rep;
      int cx;
      int cy;
      int rad;
      int lim;
      int px;
      int py;
      cx = x;
      cy = y;
      rad = r;
      rep.cell_state = CELL_UNEXPLORED;
      case (op)
         OP_DECAY: begin
            for (int i = 0; i < CELL_TOTAL; i++)
               if (grid_mirror[i] == CELL_VISIBLE) grid_mirror[i] = CELL_EXPLORED;
         end
         OP_STAMP: begin
            // radius clamped into 1..MAX_RADIUS, disc test dx^2+dy^2 <= r^2+r
            if (rad < 1) rad = 1;
            if (rad > MAX_RADIUS) rad = MAX_RADIUS;
            lim = rad * rad + rad;
            for (int dy = -rad; dy <= rad; dy++) begin
               for (int dx = -rad; dx <= rad; dx++) begin
                  px = cx + dx;
                  py = cy + dy;
                  if (grid_has(px, py) && dx * dx + dy * dy <= lim) begin
                     if (grid_mirror[py * GRID_SIDE + px] == CELL_UNEXPLORED)
                        explored_mirror++;
                     grid_mirror[py * GRID_SIDE + px] = CELL_VISIBLE;
                  end
               end
            end
         end
         OP_QUERY: begin
            // off-grid cells read as unexplored
            if (grid_has(cx, cy)) rep.cell_state = grid_mirror[cy * GRID_SIDE + cx];
         end
         default: begin
            // unused code leaves the grid alone
         end
      endcase
      rep.explored_count = COUNT_W'(explored_mirror);
      return rep;
   endfunction

   // drive one item at the falling edge and hold it until the transfer
   task automatic send_item(input logic [OP_W-1:0] op, input int x, input int y,
                            input int r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({RADIUS_W'(r), TILE_W'(y), TILE_W'(x), op});
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(apply_to_mirror(op, TILE_W'(x), TILE_W'(y), RADIUS_W'(r)));
      op_seen[op]++;
      if (op == OP_STAMP) begin
         last_cx = x;
         last_cy = y;
      end
      @(negedge clock);
   endtask

   // receiving side stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // compare every result transfer with the oldest owed report
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("result transfer with no report pending: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            oldest_report = pending_reports.pop_front();
            reports_checked++;
            if (rsp_tdata[CELL_W-1:0] !== oldest_report.cell_state) begin
               $error("cell_state mismatch: expected %0d, actual %0d",
                      oldest_report.cell_state, rsp_tdata[CELL_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[CELL_W +: COUNT_W] !== oldest_report.explored_count) begin
               $error("explored_count mismatch: expected %0d, actual %0d",
                      oldest_report.explored_count, rsp_tdata[CELL_W +: COUNT_W]);
               error_count++;
            end
         end
      end
   end

   // fresh grid reads all unexplored
   task automatic test_reset_state;
      send_item(OP_QUERY, 0, 0, 0);
      send_item(OP_QUERY, GRID_SIDE - 1, GRID_SIDE - 1, 0);
   endtask

   // disc edges, clipping at the grid borders and radius clamping
   task automatic test_disc_shapes;
      // radius 0 acts as 1, corner disc keeps only its in-grid quarter
      send_item(OP_STAMP, 0, 0, 0);
      send_item(OP_QUERY, 1, 1, 0);
      send_item(OP_QUERY, 2, 0, 0);
      // largest radius at the far corner: 31 along an axis is in, the diagonal 23,23 is out
      send_item(OP_STAMP, GRID_SIDE - 1, GRID_SIDE - 1, 31);
      send_item(OP_QUERY, GRID_SIDE - 32, GRID_SIDE - 1, 0);
      send_item(OP_QUERY, GRID_SIDE - 24, GRID_SIDE - 24, 0);
      // discs wholly off the grid change nothing
      send_item(OP_STAMP, -512, -512, 31);
      send_item(OP_STAMP, 511, 511, 31);
      // disc hanging over the left edge
      send_item(OP_STAMP, -3, 128, 5);
      send_item(OP_QUERY, 2, 128, 0);
      send_item(OP_QUERY, 0, 133, 0);
      send_item(OP_STAMP, 128, 128, 31);
   endtask

   // off-grid queries past the low-x, high-x and low-y borders, and the unused operation code
   task automatic test_off_grid_and_unused;
      send_item(OP_QUERY, -1, 0, 0);
      send_item(OP_QUERY, GRID_SIDE, 0, 0);
      send_item(OP_QUERY, 0, -1, 0);
      send_item(OP_QUERY, 511, -512, 0);
      send_item(OP_UNUSED, -1, -1, 31);
   endtask

   // visible cells fall back to explored, then a fresh stamp shows again
   task automatic test_decay;
      send_item(OP_DECAY, 0, 0, 0);
      send_item(OP_QUERY, 128, 128, 0);
      send_item(OP_STAMP, 10, GRID_SIDE - 6, 1);
      send_item(OP_QUERY, 10, GRID_SIDE - 6, 0);
      send_item(OP_DECAY, -1, -1, 31);
      send_item(OP_QUERY, 10, GRID_SIDE - 6, 0);
   endtask

   // random traffic: mostly stamps near the grid and queries that probe them
   task automatic test_random_mix(input int count);
      int pick;
      int x;
      int y;
      int r;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         x = int'($urandom_range(1023)) - 512;
         y = int'($urandom_range(1023)) - 512;
         r = $urandom_range(31);
         if (pick < 2) begin
            send_item(OP_DECAY, x, y, r);
         end else if (pick < 7) begin
            send_item(OP_UNUSED, x, y, r);
         end else if (pick < 45) begin
            // centres mostly on or just beside the grid, radii mostly small
            if ($urandom_range(9) < 8) begin
               x = int'($urandom_range(GRID_SIDE + 63)) - 32;
               y = int'($urandom_range(GRID_SIDE + 63)) - 32;
            end
            if ($urandom_range(9) < 7) r = $urandom_range(8);
            send_item(OP_STAMP, x, y, r);
         end else begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               x = last_cx + int'($urandom_range(64)) - 32;
               y = last_cy + int'($urandom_range(64)) - 32;
            end else if (pick < 80) begin
               x = $urandom_range(GRID_SIDE - 1);
               y = $urandom_range(GRID_SIDE - 1);
            end
            send_item(OP_QUERY, x, y, r);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      explored_mirror = 0;
      error_count = 0;
      reports_checked = 0;
      last_cx = GRID_SIDE / 2;
      last_cy = GRID_SIDE / 2;
      for (int i = 0; i < 4; i++) op_seen[i] = 0;
      for (int i = 0; i < CELL_TOTAL; i++) grid_mirror[i] = CELL_UNEXPLORED;
      sender_idle_pct   = 20;
      receiver_idle_pct = 71;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // the clearing pass after reset is covered by waiting on req_tready
      test_reset_state();
      test_disc_shapes();
      test_off_grid_and_unused();
      test_decay();
      test_random_mix(RANDOM_ITEMS / 3);
      sender_idle_pct   = 71;
      receiver_idle_pct = 20;
      test_random_mix(RANDOM_ITEMS / 3);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_mix(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_tvalid <= 1'b0;
      // drain: every report owed, then a short quiet stretch
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d decays, %0d disc stamps, %0d cell queries, %0d unused codes",
               op_seen[OP_DECAY], op_seen[OP_STAMP], op_seen[OP_QUERY], op_seen[OP_UNUSED]);
      $display("%0d result transfers checked under three stall patterns, %0d errors",
               reports_checked, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #(2 * HALF_PERIOD * 10_000_000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
